>>> hw/rtl/idfr_pkg.sv
// ----------------------------------------------------------------------------
// idfr_pkg
// Shared types and constants for the ID allocator with FIFO reuse of freed IDs.
// ----------------------------------------------------------------------------
package idfr_pkg;

   localparam int MAX_IDS = 1024;
   localparam int ID_W    = 10;
   localparam int CAP_W   = 11;

   localparam logic ACT_ALLOC   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_RANGE     = 2'd1;
   localparam logic [1:0] STATUS_NOT_ALLOC = 2'd2;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd3;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

   typedef struct packed {
      logic            action;
      logic [ID_W-1:0] id_in;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] id_out;
      logic [1:0]      status;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic lookup;
      logic exec;
   } ctrl_cmd_type;

endpackage

>>> hw/rtl/idfr_ram.sv
// ----------------------------------------------------------------------------
// idfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module idfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/idfr_ctrl.sv
// ----------------------------------------------------------------------------
// idfr_ctrl
// Sequencer: accept a transaction, look up memories, execute, go idle.
// ----------------------------------------------------------------------------
module idfr_ctrl
   import idfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      IDLE   = 3'b001,
      LOOKUP = 3'b010,
      EXEC   = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               state_in = LOOKUP;
            end
         end
         LOOKUP: state_in = EXEC;
         EXEC:   state_in = IDLE;
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != IDLE);
   assign cmd.load   = (state_ff == IDLE) && start;
   assign cmd.lookup = (state_ff == LOOKUP);
   assign cmd.exec   = (state_ff == EXEC);

   a_load_then_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.lookup)
      else $error("accepted transaction did not go to lookup");

   a_exec_then_free: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> !busy)
      else $error("controller not idle after execute");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.lookup, cmd.exec}))
      else $error("more than one command active");

endmodule

>>> hw/rtl/idfr_dpath.sv
// ----------------------------------------------------------------------------
// idfr_dpath
// Datapath: allocated bitmap, free ID queue, fresh counter and response reg.
// ----------------------------------------------------------------------------
module idfr_dpath
   import idfr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ctrl_cmd_type     cmd,
   input  req_type          req_data,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_data
);

   logic [CAP_W-1:0] capacity_ff;
   logic [ID_W-1:0]  head_ff, head_in;
   logic [ID_W-1:0]  tail_ff, tail_in;
   logic [CAP_W-1:0] count_ff, count_in;
   logic [CAP_W-1:0] fresh_ff, fresh_in;
   req_type          req_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_strobe_ff;

   logic [CAP_W-1:0] eff_cap;
   logic             map_wr_en;
   logic [ID_W-1:0]  map_wr_addr;
   logic             map_wr_bit;
   logic             map_rd_bit;
   logic             fifo_wr_en;
   logic [ID_W-1:0]  fifo_rd_data;
   logic             is_alloc;

   assign eff_cap = (capacity_ff > CAP_W'(MAX_IDS)) ? CAP_W'(MAX_IDS) : capacity_ff;

   // bits at or above the fresh counter are stale from before the last rebuild
   assign is_alloc = map_rd_bit && ({1'b0, req_ff.id_in} < fresh_ff);

   idfr_ram #(
      .WIDTH (1),
      .DEPTH (MAX_IDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_bit),
      .rd_en   (cmd.lookup),
      .rd_addr (req_ff.id_in),
      .rd_data (map_rd_bit)
   );

   idfr_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_IDS)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_ff.id_in),
      .rd_en   (cmd.lookup),
      .rd_addr (head_ff),
      .rd_data (fifo_rd_data)
   );

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      fresh_in    = fresh_ff;
      map_wr_en   = 1'b0;
      map_wr_addr = req_ff.id_in;
      map_wr_bit  = 1'b0;
      fifo_wr_en  = 1'b0;
      rsp_in      = rsp_ff;
      if (cmd.exec) begin
         rsp_in.id_out = '0;
         if (req_ff.action == ACT_ALLOC) begin
            priority if (count_ff != '0) begin
               head_in  = ID_W'(head_ff + 1'b1);
               count_in = CAP_W'(count_ff - 1'b1);
               if ({1'b0, fifo_rd_data} >= eff_cap) begin
                  rsp_in.status = STATUS_EXHAUSTED;
               end else begin
                  map_wr_en     = 1'b1;
                  map_wr_addr   = fifo_rd_data;
                  map_wr_bit    = 1'b1;
                  rsp_in.id_out = fifo_rd_data;
                  rsp_in.status = STATUS_OK;
               end
            end else if (fresh_ff < eff_cap) begin
               fresh_in      = CAP_W'(fresh_ff + 1'b1);
               map_wr_en     = 1'b1;
               map_wr_addr   = fresh_ff[ID_W-1:0];
               map_wr_bit    = 1'b1;
               rsp_in.id_out = fresh_ff[ID_W-1:0];
               rsp_in.status = STATUS_OK;
            end else begin
               rsp_in.status = STATUS_EXHAUSTED;
            end
         end else begin
            priority if ({1'b0, req_ff.id_in} >= eff_cap) begin
               rsp_in.status = STATUS_RANGE;
            end else if (!is_alloc) begin
               rsp_in.status = STATUS_NOT_ALLOC;
            end else begin
               map_wr_en     = 1'b1;
               map_wr_bit    = 1'b0;
               rsp_in.id_out = req_ff.id_in;
               rsp_in.status = STATUS_OK;
               if (count_ff < CAP_W'(MAX_IDS)) begin
                  fifo_wr_en = 1'b1;
                  tail_in    = ID_W'(tail_ff + 1'b1);
                  count_in   = CAP_W'(count_ff + 1'b1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAP_RESET;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         fresh_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.exec;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
            head_ff     <= '0;
            tail_ff     <= '0;
            count_ff    <= '0;
            fresh_ff    <= '0;
         end else begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
            fresh_ff <= fresh_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      tail_ff == ID_W'(head_ff + count_ff[ID_W-1:0]))
      else $error("free queue pointers and count disagree");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_W'(MAX_IDS))
      else $error("free queue count overflow");

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= eff_cap)
      else $error("fresh counter beyond capacity");

endmodule

>>> hw/rtl/id_allocator_fifo_reuse_core.sv
// ----------------------------------------------------------------------------
// id_allocator_fifo_reuse_core
// Hands out and takes back numeric IDs; freed IDs are reused oldest first.
//
//   channel   ports                        direction  qualifier
//   request   start, busy, req_data        in         start && !busy
//   response  rsp_strobe, rsp_data         out        rsp_strobe (one cycle)
//   csr       csr_wr_en, csr_wr_data       in         csr_wr_en
//
// Each transaction passes through accept, memory lookup (registered read of
// the bitmap and free queue RAMs) and execute with write-back. The response is
// shown the cycle after execute, the same cycle a new request can be taken.
// A capacity write resets pointers and counters; the bitmap needs no clearing
// since bits at or above the fresh counter read as free. Reset is synchronous.
// ----------------------------------------------------------------------------
module id_allocator_fifo_reuse_core
   import idfr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   ctrl_cmd_type cmd;

   idfr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   idfr_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

endmodule

>>> tb/id_allocator_fifo_reuse_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_allocator_fifo_reuse_core_tb
// Sends allocate and release transactions to the ID allocator and checks every
// response against a bench-side model of the allocated bitmap, the queue of
// freed IDs and the fresh-ID counter. Directed cases cover capacity extremes,
// reuse order and every error status. Random traffic then runs at several
// capacities and with several amounts of request idling.
// ----------------------------------------------------------------------------
module id_allocator_fifo_reuse_core_tb;
   import idfr_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int MAX_REPORTS = 10;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_strobe;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   // bench copy of the allocator state
   logic [CAP_W-1:0] cap_reg;
   bit               id_taken [MAX_IDS];
   logic [ID_W-1:0]  freed_ids [$];
   int               fresh_next;
   logic [ID_W-1:0]  held_ids [$];
   rsp_type          outcome_q [$];

   int fail_count      = 0;
   int cycle_count     = 0;
   int sender_idle_pct = 0;

   always #6 clock = ~clock;

   id_allocator_fifo_reuse_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   function automatic int effective_capacity();
      return (cap_reg > MAX_IDS) ? MAX_IDS : int'(cap_reg);
   endfunction

   task automatic reinit_model(input logic [CAP_W-1:0] value);
      cap_reg = value;
      foreach (id_taken[i]) id_taken[i] = 1'b0;
      freed_ids.delete();
      held_ids.delete();
      fresh_next = 0;
   endtask

   task automatic compute_outcome(input req_type item);
      int              eff_cap;
      logic [ID_W-1:0] id;
      bit              granted;
      rsp_type         r;
      eff_cap  = effective_capacity();
      granted  = 1'b0;
      r.id_out = '0;
      r.status = STATUS_OK;
      if (item.action == ACT_ALLOC) begin
         if (freed_ids.size() != 0) begin
            id      = freed_ids.pop_front();
            granted = (id < eff_cap);
         end else if (fresh_next < eff_cap) begin
            id      = ID_W'(fresh_next);
            granted = 1'b1;
            fresh_next++;
         end
         if (granted) begin
            id_taken[id] = 1'b1;
            held_ids.push_back(id);
            r.id_out = id;
         end else begin
            r.status = STATUS_EXHAUSTED;
         end
      end else begin
         id = item.id_in;
         if (id >= eff_cap) begin
            r.status = STATUS_RANGE;
         end else if (!id_taken[id]) begin
            r.status = STATUS_NOT_ALLOC;
         end else begin
            id_taken[id] = 1'b0;
            // guard only: queued IDs never outnumber the capacity
            if (freed_ids.size() < MAX_IDS) freed_ids.push_back(id);
            for (int i = 0; i < held_ids.size(); i++) begin
               if (held_ids[i] == id) begin
                  held_ids.delete(i);
                  break;
               end
            end
            r.id_out = id;
         end
      end
      outcome_q.push_back(r);
   endtask

   // one transaction; start stays high afterwards unless the next call idles
   task automatic issue_request(input logic action, input logic [ID_W-1:0] id);
      req_type item;
      item.action = action;
      item.id_in  = id;
      if ($urandom_range(99, 0) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      compute_outcome(item);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      start <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      reinit_model(value);
   endtask

   function automatic logic [ID_W-1:0] pick_release_id();
      int sel;
      sel = $urandom_range(99, 0);
      if (sel < 60 && held_ids.size() != 0)
         return held_ids[$urandom_range(held_ids.size() - 1, 0)];
      if (sel < 80)
         return ID_W'($urandom_range(1023, 0));
      // right around the capacity edge
      return ID_W'(effective_capacity() - 1 + $urandom_range(2, 0));
   endfunction

   task automatic test_fresh_and_reuse();
      issue_request(ACT_ALLOC, 10'h3ff);
      issue_request(ACT_ALLOC, 10'h000);
      issue_request(ACT_ALLOC, 10'h155);
      issue_request(ACT_RELEASE, 10'd1);
      issue_request(ACT_RELEASE, 10'd1);
      issue_request(ACT_RELEASE, 10'd1023);
      issue_request(ACT_ALLOC, 10'h2aa);
      issue_request(ACT_ALLOC, 10'h000);
   endtask

   task automatic test_capacity_zero();
      write_capacity('0);
      issue_request(ACT_ALLOC, 10'h000);
      issue_request(ACT_RELEASE, 10'd0);
      issue_request(ACT_RELEASE, 10'd1023);
   endtask

   task automatic test_capacity_one();
      write_capacity(CAP_W'(1));
      issue_request(ACT_ALLOC, 10'h000);
      issue_request(ACT_ALLOC, 10'h000);
      issue_request(ACT_RELEASE, 10'd1);
      issue_request(ACT_RELEASE, 10'd0);
      issue_request(ACT_ALLOC, 10'h3ff);
   endtask

   // capacity above the ID space saturates; freed IDs come back oldest first
   task automatic test_capacity_saturated();
      write_capacity('1);
      issue_request(ACT_ALLOC, 10'h000);
      issue_request(ACT_ALLOC, 10'h000);
      issue_request(ACT_ALLOC, 10'h000);
      issue_request(ACT_RELEASE, 10'd2);
      issue_request(ACT_RELEASE, 10'd0);
      issue_request(ACT_RELEASE, 10'd1023);
      issue_request(ACT_ALLOC, 10'h000);
      issue_request(ACT_ALLOC, 10'h000);
   endtask

   task automatic test_random_traffic();
      int               idle_mode [3] = '{37, 71, 0};
      logic [CAP_W-1:0] cap;
      foreach (idle_mode[p]) begin
         sender_idle_pct = idle_mode[p];
         for (int s = 0; s < 4; s++) begin
            case ($urandom_range(5, 0))
               0: cap = '0;
               1: cap = CAP_W'($urandom_range(4, 1));
               2: cap = CAP_W'($urandom_range(64, 5));
               3: cap = CAP_W'($urandom_range(1023, 65));
               4: cap = CAP_RESET;
               default: cap = CAP_W'($urandom_range(2047, 1025));
            endcase
            write_capacity(cap);
            repeat (50) begin
               if ($urandom_range(1, 0))
                  issue_request(ACT_ALLOC, ID_W'($urandom_range(1023, 0)));
               else
                  issue_request(ACT_RELEASE, pick_release_id());
            end
         end
      end
   endtask

   always @(posedge clock) begin : check_outcome
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (outcome_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected response: id_out=%0d status=%0d",
                        rsp_data.id_out, rsp_data.status);
         end else begin
            want = outcome_q.pop_front();
            if (rsp_data.id_out !== want.id_out || rsp_data.status !== want.status) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("mismatch: exp id_out=%0d status=%0d, got id_out=%0d status=%0d",
                           want.id_out, want.status, rsp_data.id_out, rsp_data.status);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset       <= 1'b1;
      start       <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      reinit_model(CAP_RESET);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_fresh_and_reuse();
      test_capacity_zero();
      test_capacity_one();
      test_capacity_saturated();
      test_random_traffic();

      start <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> id_allocator_fifo_reuse_core.f
hw/rtl/idfr_pkg.sv
hw/rtl/idfr_ram.sv
hw/rtl/idfr_ctrl.sv
hw/rtl/idfr_dpath.sv
hw/rtl/id_allocator_fifo_reuse_core.sv
tb/id_allocator_fifo_reuse_core_tb.sv
